### src/pdts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdts_pkg
// Shared types and constants for the packed depth table store.
// ----------------------------------------------------------------------------
package pdts_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NIB_PER_G = 16;  // 4-bit entries per group word
  localparam int unsigned PAIR_PER_G = 32; // 2-bit entries per group word
  localparam int unsigned IDX_W     = 21;
  localparam int unsigned RADIX_W   = 19;
  localparam int unsigned LIM_W     = 27; // wide enough for any table limit
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned VAL_W     = 5;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  localparam logic [1:0] SEL_MAIN  = 2'd0;
  localparam logic [1:0] SEL_FIRST = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;
  localparam logic [1:0] SEL_BAD   = 2'd3;

  localparam logic [1:0] REG_COMPACT = 2'd0;
  localparam logic [1:0] REG_BASE    = 2'd1;
  localparam logic [1:0] REG_LO_SIZE = 2'd2;
  localparam logic [1:0] REG_HI_SIZE = 2'd3;

  typedef struct packed {
    logic cap;       // latch the input transaction, clear result
    logic rd;        // read all three stores
    logic fb;        // read addresses from split base indexes
    logic div_start;
    logic div_sel;   // 0: index by low radix, 1: quotient by high radix
    logic cap_lo;
    logic cap_hi;
    logic set_err;
    logic set_nib;
    logic set_pair;
    logic set_max;
    logic wr_upd;
    logic wr_ld;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_nop;
    logic is_load;
    logic is_update;
    logic compact_rd;
    logic range_bad;
    logic pair_zero;
    logic lower;
    logic div_done;
    logic fb_bad;
  } dp_sts_t;

endpackage

### src/pdts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdts_div
// Restoring divider, one quotient bit per cycle; zero divisor taken as one.
// ----------------------------------------------------------------------------
module pdts_div
  import pdts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [IDX_W-1:0]   dividend,
  input  logic [RADIX_W-1:0] divisor,
  output logic               done,
  output logic [IDX_W-1:0]   quotient,
  output logic [RADIX_W-1:0] remainder
);

  localparam int unsigned STEP_W = $clog2(IDX_W + 1);

  logic [IDX_W-1:0]   q_r;
  logic [RADIX_W-1:0] rem_r;
  logic [RADIX_W-1:0] d_r;
  logic [STEP_W-1:0]  steps_r;
  logic               busy_r;
  logic               done_r;
  logic [RADIX_W:0]   shifted;
  logic               ge;

  assign shifted = {rem_r, q_r[IDX_W-1]};
  assign ge      = shifted >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        steps_r <= STEP_W'(IDX_W);
      end else if (busy_r) begin
        steps_r <= steps_r - 1'b1;
        if (steps_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= (divisor == '0) ? RADIX_W'(1) : divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[IDX_W-2:0], ge};
      rem_r <= ge ? RADIX_W'(shifted - {1'b0, d_r}) : shifted[RADIX_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### src/pdts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdts_dp
// Datapath: three group-word stores, index split, result and counter.
// ----------------------------------------------------------------------------
module pdts_dp
  import pdts_pkg::*;
#(
  parameter int unsigned MAIN_GROUPS = 65536,
  parameter int unsigned BASE_GROUPS = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_sel,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [3:0]         in_depth,
  input  logic [WORD_W-1:0]  in_word,
  input  logic               compact_mode,
  input  logic [3:0]         depth_base,
  input  logic [RADIX_W-1:0] lo_size,
  input  logic [RADIX_W-1:0] hi_size,
  output logic [VAL_W-1:0]   out_value,
  output logic               out_written,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_err
);

  localparam int unsigned MAW = (MAIN_GROUPS > 1) ? $clog2(MAIN_GROUPS) : 1;
  localparam int unsigned BAW = (BASE_GROUPS > 1) ? $clog2(BASE_GROUPS) : 1;
  localparam logic [LIM_W-1:0] MAIN_LIM_G  = LIM_W'(MAIN_GROUPS);
  localparam logic [LIM_W-1:0] MAIN_LIM_E4 = LIM_W'(MAIN_GROUPS * NIB_PER_G);
  localparam logic [LIM_W-1:0] MAIN_LIM_E2 = LIM_W'(MAIN_GROUPS * PAIR_PER_G);
  localparam logic [LIM_W-1:0] BASE_LIM_G  = LIM_W'(BASE_GROUPS);
  localparam logic [LIM_W-1:0] BASE_LIM_E4 = LIM_W'(BASE_GROUPS * NIB_PER_G);

  logic [WORD_W-1:0] main_mem   [MAIN_GROUPS];
  logic [WORD_W-1:0] first_mem  [BASE_GROUPS];
  logic [WORD_W-1:0] second_mem [BASE_GROUPS];
  logic [WORD_W-1:0] main_rd_r, first_rd_r, second_rd_r;

  logic [1:0]         mode_r, sel_r;
  logic [IDX_W-1:0]   idx_r;
  logic [3:0]         depth_r;
  logic [WORD_W-1:0]  word_r;
  logic [RADIX_W-1:0] lo_r, hi_r;
  logic [VAL_W-1:0]   value_r;
  logic               written_r, err_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_written_r, out_err_r;
  logic [CNT_W-1:0]   out_count_r;

  logic [LIM_W-1:0]   idx_ext, lo_ext, hi_ext, lim;
  logic               compact_rd;
  logic [MAW-1:0]     main_ra, main_wa;
  logic [BAW-1:0]     first_ra, second_ra, base_wa;
  logic [WORD_W-1:0]  sel_word, upd_word, wr_word;
  logic [5:0]         nib_sh;
  logic [3:0]         nib, nib_a, nib_b;
  logic [1:0]         pair;
  logic               div_done;
  logic [IDX_W-1:0]   div_q;
  logic [RADIX_W-1:0] div_rem;

  assign idx_ext    = LIM_W'(idx_r);
  assign lo_ext     = LIM_W'(lo_r);
  assign hi_ext     = LIM_W'(hi_r);
  assign compact_rd = compact_mode && (sel_r == SEL_MAIN) && (mode_r == MODE_READ);

  always_comb begin
    lim = '0;
    case (sel_r)
      SEL_MAIN: begin
        if (mode_r == MODE_LOAD) lim = MAIN_LIM_G;
        else if (compact_rd)     lim = MAIN_LIM_E2;
        else                     lim = MAIN_LIM_E4;
      end
      SEL_FIRST, SEL_SECOND: begin
        lim = (mode_r == MODE_LOAD) ? BASE_LIM_G : BASE_LIM_E4;
      end
      default: lim = '0;
    endcase
  end

  // addresses: entry index drops its in-word bits, a load uses it whole
  assign main_ra   = compact_rd ? idx_ext[5 +: MAW] : idx_ext[4 +: MAW];
  assign main_wa   = cmd.wr_ld ? idx_ext[0 +: MAW] : idx_ext[4 +: MAW];
  assign base_wa   = cmd.wr_ld ? idx_ext[0 +: BAW] : idx_ext[4 +: BAW];
  assign first_ra  = cmd.fb ? hi_ext[4 +: BAW] : idx_ext[4 +: BAW];
  assign second_ra = cmd.fb ? lo_ext[4 +: BAW] : idx_ext[4 +: BAW];

  always_comb begin
    case (sel_r)
      SEL_FIRST:  sel_word = first_rd_r;
      SEL_SECOND: sel_word = second_rd_r;
      default:    sel_word = main_rd_r;
    endcase
  end

  assign nib_sh   = {idx_r[3:0], 2'b00};
  assign nib      = 4'(sel_word >> nib_sh);
  assign pair     = 2'(main_rd_r >> {idx_r[4:0], 1'b0});
  assign nib_a    = 4'(second_rd_r >> {lo_r[3:0], 2'b00});
  assign nib_b    = 4'(first_rd_r >> {hi_r[3:0], 2'b00});
  assign upd_word = (sel_word & ~(64'hF << nib_sh)) | (WORD_W'(depth_r) << nib_sh);
  assign wr_word  = cmd.wr_ld ? word_r : upd_word;

  always_ff @(posedge clk) begin
    if ((cmd.wr_upd || cmd.wr_ld) && sel_r == SEL_MAIN) main_mem[main_wa] <= wr_word;
    if (cmd.rd) main_rd_r <= main_mem[main_ra];
  end

  always_ff @(posedge clk) begin
    if ((cmd.wr_upd || cmd.wr_ld) && sel_r == SEL_FIRST) first_mem[base_wa] <= wr_word;
    if (cmd.rd) first_rd_r <= first_mem[first_ra];
  end

  always_ff @(posedge clk) begin
    if ((cmd.wr_upd || cmd.wr_ld) && sel_r == SEL_SECOND) second_mem[base_wa] <= wr_word;
    if (cmd.rd) second_rd_r <= second_mem[second_ra];
  end

  pdts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (cmd.div_sel ? div_q : idx_r),
    .divisor   (cmd.div_sel ? hi_size : lo_size),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r  <= in_mode;
      sel_r   <= in_sel;
      idx_r   <= in_index;
      depth_r <= in_depth;
      word_r  <= in_word;
    end
    if (cmd.cap_lo) lo_r <= div_rem;
    if (cmd.cap_hi) hi_r <= div_rem;
    if (cmd.out_load) begin
      out_value_r   <= value_r;
      out_written_r <= written_r;
      out_err_r     <= err_r;
      out_count_r   <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      value_r   <= '0;
      written_r <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      if (cmd.cap) begin
        value_r   <= '0;
        written_r <= 1'b0;
        err_r     <= 1'b0;
      end
      if (cmd.set_err)  err_r   <= 1'b1;
      if (cmd.set_nib)  value_r <= VAL_W'(nib);
      if (cmd.set_pair) value_r <= VAL_W'(pair) + VAL_W'(depth_base);
      if (cmd.set_max)  value_r <= VAL_W'((nib_a > nib_b) ? nib_a : nib_b);
      if (cmd.wr_ld)    written_r <= 1'b1;
      if (cmd.wr_upd) begin
        written_r <= 1'b1;
        if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign sts.is_nop     = (mode_r == MODE_NOP);
  assign sts.is_load    = (mode_r == MODE_LOAD);
  assign sts.is_update  = (mode_r == MODE_UPDATE);
  assign sts.compact_rd = compact_rd;
  assign sts.range_bad  = (idx_ext >= lim);
  assign sts.pair_zero  = (pair == 2'd0);
  assign sts.lower      = (nib > depth_r);
  assign sts.div_done   = div_done;
  assign sts.fb_bad     = (lo_ext >= BASE_LIM_E4) || (hi_ext >= BASE_LIM_E4);

  assign out_value   = out_value_r;
  assign out_written = out_written_r;
  assign out_count   = out_count_r;
  assign out_err     = out_err_r;

endmodule

### src/pdts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdts_ctrl
// Sequencer: one transaction at a time through read, split and write steps.
// ----------------------------------------------------------------------------
module pdts_ctrl
  import pdts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_RDWAIT, S_DIV1, S_DIV2S, S_DIV2, S_FBCHK, S_FBWAIT, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    cmd            = '0;
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.is_nop) begin
          state_nxt = S_FIN;
        end else if (sts.range_bad) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_FIN;
        end else if (sts.is_load) begin
          cmd.wr_ld = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        if (sts.is_update) begin
          cmd.set_nib = 1'b1;
          cmd.wr_upd  = sts.lower;
          state_nxt   = S_FIN;
        end else if (sts.compact_rd && !sts.pair_zero) begin
          cmd.set_pair = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.compact_rd) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV1;
        end else begin
          cmd.set_nib = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.cap_lo = 1'b1;
          state_nxt  = S_DIV2S;
        end
      end
      S_DIV2S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.cap_hi = 1'b1;
          state_nxt  = S_FBCHK;
        end
      end
      S_FBCHK: begin
        if (sts.fb_bad) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          cmd.fb    = 1'b1;
          state_nxt = S_FBWAIT;
        end
      end
      S_FBWAIT: begin
        cmd.set_max = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

### src/packed_depth_table_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_depth_table_store
// Depth tables packed into 64-bit group words, with compact-mode fallback.
// ----------------------------------------------------------------------------
// One transaction at a time. A load, an out-of-range index or an unused mode
// goes from the issue step straight to the result; a read or an update adds
// one registered memory read, the update writing back in the same step. A
// compact read of a zero 2-bit entry splits the index with two passes of a
// shared one-bit-per-cycle divider and then reads both base tables. The next
// transaction is accepted the cycle after the result is handed to the output
// register, so a result that waits for out_tready stalls the input only once
// the next one is ready too.
// Stores come up undefined; read only words that were loaded.
// ----------------------------------------------------------------------------
module packed_depth_table_store
  import pdts_pkg::*;
#(
  parameter int unsigned MAIN_GROUPS = 65536,
  parameter int unsigned BASE_GROUPS = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  // fields low to high: mode[1:0], table_select[3:2], index[24:4],
  // depth[28:25], group_word[92:29], zero pad[95:93]
  input  logic [95:0]        in_tdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  // fields low to high: entry_value[4:0], was_written[5],
  // write_count[37:6], range_error[38], zero pad[39]
  output logic [39:0]        out_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [RADIX_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration: the user writes it only while idle; the block does not enforce it
  logic               compact_r;
  logic [3:0]         base_r;
  logic [RADIX_W-1:0] lo_size_r, hi_size_r;

  logic [VAL_W-1:0] out_value;
  logic             out_written, out_err;
  logic [CNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compact_r <= 1'b0;
      base_r    <= '0;
      lo_size_r <= RADIX_W'(1);
      hi_size_r <= RADIX_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COMPACT: compact_r <= cfg_wdata[0];
        REG_BASE:    base_r    <= cfg_wdata[3:0];
        REG_LO_SIZE: lo_size_r <= cfg_wdata;
        REG_HI_SIZE: hi_size_r <= cfg_wdata;
        default:     compact_r <= compact_r;
      endcase
    end
  end

  pdts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pdts_dp #(
    .MAIN_GROUPS (MAIN_GROUPS),
    .BASE_GROUPS (BASE_GROUPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_tdata[1:0]),
    .in_sel       (in_tdata[3:2]),
    .in_index     (in_tdata[24:4]),
    .in_depth     (in_tdata[28:25]),
    .in_word      (in_tdata[92:29]),
    .compact_mode (compact_r),
    .depth_base   (base_r),
    .lo_size      (lo_size_r),
    .hi_size      (hi_size_r),
    .out_value    (out_value),
    .out_written  (out_written),
    .out_count    (out_count),
    .out_err      (out_err)
  );

  assign out_tdata = {1'b0, out_err, out_count, out_written, out_value};

  // one transaction in flight: accept closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a transaction is in flight");

  // a range error never writes and never returns a depth
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[38]) |-> (!out_tdata[5] && out_tdata[4:0] == 5'd0))
    else $error("range error with write or value");

  // the update count never goes back
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && $past(out_tvalid) && $past(rst_n))
      |-> (out_tdata[37:6] >= $past(out_tdata[37:6])))
    else $error("write count decreased");

endmodule
